// ===== rtl/core/bcdir_pkg.sv =====
// Shared constants, types and command/status structs for the block cache directory.
package bcdir_pkg;

    localparam int ENTRIES     = 64;
    localparam int BLOCK_BITS  = 64;
    localparam int MAX_RESULTS = 64;
    localparam int PIN_BITS    = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int RANK_W      = IDX_W;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [BLOCK_BITS-1:0] BLOCK_MASK = {BLOCK_BITS{1'b1}};
    localparam logic [PIN_BITS-1:0]   PIN_MAX    = {PIN_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_GET     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DIRTY   = 2'd2,
        KIND_SYNC    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        RES_HIT       = 3'd0,
        RES_FILL      = 3'd1,
        RES_WRITEBACK = 3'd2,
        RES_NOFREE    = 3'd3,
        RES_ACK       = 3'd4,
        RES_UNDERFLOW = 3'd5
    } result_t;

    typedef enum logic [2:0] {
        EMIT_NOFREE,
        EMIT_HIT,
        EMIT_FILL,
        EMIT_FILL_NEW,
        EMIT_VICTIM_WB,
        EMIT_SLOT,
        EMIT_SLOT_EMPTY,
        EMIT_SYNC_WB
    } emit_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_EVAL,
        ST_DECIDE,
        ST_VIC_WAIT,
        ST_TOUCH_RD,
        ST_TOUCH_EVAL,
        ST_FILL_NEW,
        ST_SLOT_RD,
        ST_SLOT_EVAL,
        ST_SYNC_RD,
        ST_SYNC_EVAL,
        ST_SYNC_WAIT,
        ST_SYNC_ACK
    } state_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] tag;
        logic [PIN_BITS-1:0]   pin;
        logic                  dirty;
        logic [RANK_W-1:0]     rank;
    } entry_t;

    typedef struct packed {
        logic  load;
        logic  mem_rd;
        logic  rd_slot;
        logic  idx_clr;
        logic  idx_inc;
        logic  search_step;
        logic  take_victim;
        logic  evict_dirty;
        logic  touch_write;
        logic  new_write;
        logic  slot_write;
        logic  sync_clear;
        logic  emit;
        emit_t emit_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  out_busy;
        kind_t kind;
        logic  blk_marker;
        logic  slot_valid;
        logic  idx_done;
        logic  hit;
        logic  full;
        logic  vic_found;
        logic  vic_dirty;
        logic  rd_dirty;
        logic  dirty_zero;
        logic  emitted_zero;
        logic  cap;
    } dp_stat_t;

endpackage

// ===== rtl/core/bcdir_ctrl.sv =====
// Controller state machine that sequences lookups, rank updates, slot ops and sync walks.
module bcdir_ctrl
    import bcdir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !stat.out_busy)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.kind)
                    KIND_GET:
                    begin
                        state_next = stat.blk_marker ? ST_IDLE : ST_SRCH_RD;
                    end
                    KIND_RELEASE, KIND_DIRTY:
                    begin
                        state_next = stat.slot_valid ? ST_SLOT_RD : ST_IDLE;
                    end
                    KIND_SYNC:
                    begin
                        state_next = ST_SYNC_RD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SRCH_RD:
            begin
                state_next = stat.idx_done ? ST_DECIDE : ST_SRCH_EVAL;
            end
            ST_SRCH_EVAL:
            begin
                state_next = ST_SRCH_RD;
            end
            ST_DECIDE:
            begin
                priority if (stat.hit)
                begin
                    state_next = ST_TOUCH_RD;
                end
                else if (!stat.full)
                begin
                    state_next = ST_FILL_NEW;
                end
                else if (stat.vic_found)
                begin
                    state_next = stat.vic_dirty ? ST_VIC_WAIT : ST_TOUCH_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_VIC_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_TOUCH_RD;
                end
            end
            ST_TOUCH_RD:
            begin
                state_next = stat.idx_done ? ST_IDLE : ST_TOUCH_EVAL;
            end
            ST_TOUCH_EVAL:
            begin
                state_next = ST_TOUCH_RD;
            end
            ST_FILL_NEW:
            begin
                state_next = ST_IDLE;
            end
            ST_SLOT_RD:
            begin
                state_next = ST_SLOT_EVAL;
            end
            ST_SLOT_EVAL:
            begin
                state_next = ST_IDLE;
            end
            ST_SYNC_RD:
            begin
                if (stat.dirty_zero || stat.idx_done || stat.cap)
                begin
                    state_next = stat.emitted_zero ? ST_SYNC_ACK : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SYNC_EVAL;
                end
            end
            ST_SYNC_EVAL:
            begin
                state_next = stat.rd_dirty ? ST_SYNC_WAIT : ST_SYNC_RD;
            end
            ST_SYNC_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_SYNC_RD;
                end
            end
            ST_SYNC_ACK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd       = '0;
        cmd.emit_sel = EMIT_NOFREE;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = !stat.out_busy;
                cmd.load  = req_valid && !stat.out_busy;
            end
            ST_DECODE:
            begin
                unique case (stat.kind)
                    KIND_GET:
                    begin
                        cmd.emit     = stat.blk_marker;
                        cmd.emit_sel = EMIT_NOFREE;
                    end
                    KIND_RELEASE, KIND_DIRTY:
                    begin
                        cmd.emit     = !stat.slot_valid;
                        cmd.emit_sel = EMIT_SLOT_EMPTY;
                    end
                    default:
                    begin
                        cmd.emit = 1'b0;
                    end
                endcase
            end
            ST_SRCH_RD:
            begin
                cmd.mem_rd = !stat.idx_done;
            end
            ST_SRCH_EVAL:
            begin
                cmd.search_step = 1'b1;
                cmd.idx_inc     = 1'b1;
            end
            ST_DECIDE:
            begin
                priority if (stat.hit)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else if (!stat.full)
                begin
                    cmd.emit = 1'b0;
                end
                else if (stat.vic_found)
                begin
                    cmd.idx_clr     = 1'b1;
                    cmd.take_victim = 1'b1;
                    cmd.evict_dirty = stat.vic_dirty;
                    cmd.emit        = stat.vic_dirty;
                    cmd.emit_sel    = EMIT_VICTIM_WB;
                end
                else
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_NOFREE;
                end
            end
            ST_TOUCH_RD:
            begin
                cmd.mem_rd   = !stat.idx_done;
                cmd.emit     = stat.idx_done;
                cmd.emit_sel = stat.hit ? EMIT_HIT : EMIT_FILL;
            end
            ST_TOUCH_EVAL:
            begin
                cmd.touch_write = 1'b1;
                cmd.idx_inc     = 1'b1;
            end
            ST_FILL_NEW:
            begin
                cmd.new_write = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_sel  = EMIT_FILL_NEW;
            end
            ST_SLOT_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_slot = 1'b1;
            end
            ST_SLOT_EVAL:
            begin
                cmd.slot_write = 1'b1;
                cmd.emit       = 1'b1;
                cmd.emit_sel   = EMIT_SLOT;
            end
            ST_SYNC_RD:
            begin
                cmd.mem_rd = !(stat.dirty_zero || stat.idx_done || stat.cap);
            end
            ST_SYNC_EVAL:
            begin
                cmd.idx_inc    = 1'b1;
                cmd.sync_clear = stat.rd_dirty;
                cmd.emit       = stat.rd_dirty;
                cmd.emit_sel   = EMIT_SYNC_WB;
            end
            ST_SYNC_ACK:
            begin
                // Nothing dirty: a lone ack, sent through the slot-empty path with
                // slot and tag both zero.
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_SLOT_EMPTY;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bcdir_dp.sv =====
// Datapath: entry memory, scan registers, counters and the result register.
module bcdir_dp
    import bcdir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            kind,
    input  logic [63:0]           block_number,
    input  logic [5:0]            slot_index,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [2:0]            result_kind,
    output logic [5:0]            slot,
    output logic [63:0]           block_id,
    output logic                  last,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    kind_t                 kind_reg;
    logic [BLOCK_BITS-1:0] blk_reg;
    logic [5:0]            slot_reg;
    logic                  sync_ack_reg;

    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      fill_count_reg;
    logic [CNT_W-1:0]      dirty_count_reg;
    logic [RES_W-1:0]      emitted_reg;

    logic                  hit_reg;
    logic [IDX_W-1:0]      target_idx_reg;
    logic [RANK_W-1:0]     target_rank_reg;
    logic                  vic_found_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [RANK_W-1:0]     vic_rank_reg;
    logic [BLOCK_BITS-1:0] vic_tag_reg;
    logic                  vic_dirty_reg;

    logic                  out_valid_reg;
    logic [2:0]            out_kind_reg;
    logic [5:0]            out_slot_reg;
    logic [63:0]           out_blk_reg;
    logic                  out_last_reg;

    logic [IDX_W-1:0]      cur_idx;
    logic [IDX_W-1:0]      slot_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic [RANK_W-1:0]     top_rank;
    logic                  slot_in_range;
    logic                  slot_filled;
    result_t               emit_kind;
    logic [5:0]            emit_slot;
    logic [63:0]           emit_blk;
    logic                  emit_last;

    assign cur_idx       = idx_reg[IDX_W-1:0];
    assign slot_addr     = IDX_W'(slot_reg);
    assign rd_addr       = cmd.rd_slot ? slot_addr : cur_idx;
    assign top_rank      = RANK_W'(fill_count_reg - CNT_W'(1));
    assign slot_in_range = 32'(slot_reg) < ENTRIES;
    assign slot_filled   = 32'(slot_reg) < 32'(fill_count_reg);

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Write port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_idx;
        wr_data = rd_data_reg;
        priority if (cmd.touch_write)
        begin
            wr_en = 1'b1;
            if (cur_idx == target_idx_reg)
            begin
                if (hit_reg)
                begin
                    if (rd_data_reg.pin != PIN_MAX)
                    begin
                        wr_data.pin = rd_data_reg.pin + PIN_BITS'(1);
                    end
                end
                else
                begin
                    wr_data.tag   = blk_reg;
                    wr_data.pin   = PIN_BITS'(1);
                    wr_data.dirty = 1'b0;
                end
                wr_data.rank = top_rank;
            end
            else if (rd_data_reg.rank > target_rank_reg)
            begin
                wr_data.rank = rd_data_reg.rank - RANK_W'(1);
            end
        end
        else if (cmd.new_write)
        begin
            wr_en         = 1'b1;
            wr_addr       = IDX_W'(fill_count_reg);
            wr_data.tag   = blk_reg;
            wr_data.pin   = PIN_BITS'(1);
            wr_data.dirty = 1'b0;
            wr_data.rank  = RANK_W'(fill_count_reg);
        end
        else if (cmd.slot_write)
        begin
            wr_addr = slot_addr;
            if (kind_reg == KIND_RELEASE)
            begin
                wr_en       = rd_data_reg.pin != '0;
                wr_data.pin = rd_data_reg.pin - PIN_BITS'(1);
            end
            else
            begin
                wr_en         = 1'b1;
                wr_data.dirty = 1'b1;
            end
        end
        else if (cmd.sync_clear)
        begin
            wr_en         = 1'b1;
            wr_data.dirty = 1'b0;
        end
    end

    // Request, scan and search registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_GET;
            idx_reg         <= '0;
            emitted_reg     <= '0;
            hit_reg         <= 1'b0;
            vic_found_reg   <= 1'b0;
            sync_ack_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg      <= kind_t'(kind);
                idx_reg       <= '0;
                emitted_reg   <= '0;
                hit_reg       <= 1'b0;
                vic_found_reg <= 1'b0;
                sync_ack_reg  <= kind_t'(kind) == KIND_SYNC;
            end
            else if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.search_step)
            begin
                if (rd_data_reg.tag == blk_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (rd_data_reg.pin == '0 &&
                    (!vic_found_reg || rd_data_reg.rank < vic_rank_reg))
                begin
                    vic_found_reg <= 1'b1;
                end
            end
            if (cmd.sync_clear)
            begin
                emitted_reg <= emitted_reg + RES_W'(1);
            end
        end
    end

    // Request payload and search results; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blk_reg  <= block_number[BLOCK_BITS-1:0];
            slot_reg <= slot_index;
        end
        if (cmd.search_step)
        begin
            if (rd_data_reg.tag == blk_reg)
            begin
                target_idx_reg  <= cur_idx;
                target_rank_reg <= rd_data_reg.rank;
            end
            if (rd_data_reg.pin == '0 &&
                (!vic_found_reg || rd_data_reg.rank < vic_rank_reg))
            begin
                vic_idx_reg   <= cur_idx;
                vic_rank_reg  <= rd_data_reg.rank;
                vic_tag_reg   <= rd_data_reg.tag;
                vic_dirty_reg <= rd_data_reg.dirty;
            end
        end
        if (cmd.take_victim)
        begin
            target_idx_reg  <= vic_idx_reg;
            target_rank_reg <= vic_rank_reg;
        end
    end

    // Fill and dirty counters; slots fill lowest first and never empty again.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg  <= '0;
            dirty_count_reg <= '0;
        end
        else
        begin
            if (cmd.new_write)
            begin
                fill_count_reg <= fill_count_reg + CNT_W'(1);
            end
            if (cmd.evict_dirty || cmd.sync_clear)
            begin
                dirty_count_reg <= dirty_count_reg - CNT_W'(1);
            end
            else if (cmd.slot_write && kind_reg == KIND_DIRTY && !rd_data_reg.dirty)
            begin
                dirty_count_reg <= dirty_count_reg + CNT_W'(1);
            end
        end
    end

    // Result beat contents.
    always_comb
    begin
        emit_kind = RES_ACK;
        emit_slot = '0;
        emit_blk  = '0;
        emit_last = 1'b1;
        unique case (cmd.emit_sel)
            EMIT_NOFREE:
            begin
                emit_kind = RES_NOFREE;
                emit_blk  = 64'(blk_reg);
            end
            EMIT_HIT:
            begin
                emit_kind = RES_HIT;
                emit_slot = 6'(target_idx_reg);
                emit_blk  = 64'(blk_reg);
            end
            EMIT_FILL:
            begin
                emit_kind = RES_FILL;
                emit_slot = 6'(target_idx_reg);
                emit_blk  = 64'(blk_reg);
            end
            EMIT_FILL_NEW:
            begin
                emit_kind = RES_FILL;
                emit_slot = 6'(fill_count_reg);
                emit_blk  = 64'(blk_reg);
            end
            EMIT_VICTIM_WB:
            begin
                emit_kind = RES_WRITEBACK;
                emit_slot = 6'(vic_idx_reg);
                emit_blk  = 64'(vic_tag_reg);
                emit_last = 1'b0;
            end
            EMIT_SLOT:
            begin
                emit_kind = (kind_reg == KIND_RELEASE && rd_data_reg.pin == '0) ?
                            RES_UNDERFLOW : RES_ACK;
                emit_slot = slot_reg;
                emit_blk  = 64'(rd_data_reg.tag);
            end
            EMIT_SLOT_EMPTY:
            begin
                // Also serves the sync that finds nothing dirty.
                emit_kind = (kind_reg == KIND_RELEASE && slot_in_range) ?
                            RES_UNDERFLOW : RES_ACK;
                emit_slot = sync_ack_reg ? 6'd0 : slot_reg;
            end
            EMIT_SYNC_WB:
            begin
                emit_kind = RES_WRITEBACK;
                emit_slot = 6'(idx_reg);
                emit_blk  = 64'(rd_data_reg.tag);
                emit_last = (dirty_count_reg == CNT_W'(1)) ||
                            (emitted_reg == RES_W'(MAX_RESULTS - 1));
            end
            default:
            begin
                emit_kind = RES_ACK;
            end
        endcase
    end

    // Output register: one result beat waits here for the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= emit_kind;
            out_slot_reg <= emit_slot;
            out_blk_reg  <= emit_blk;
            out_last_reg <= emit_last;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign slot        = out_slot_reg;
    assign block_id    = out_blk_reg;
    assign last        = out_last_reg;

    // Status toward the controller.
    assign stat.out_busy     = out_valid_reg;
    assign stat.kind         = kind_reg;
    assign stat.blk_marker   = blk_reg == BLOCK_MASK;
    assign stat.slot_valid   = slot_filled;
    assign stat.idx_done     = idx_reg == fill_count_reg;
    assign stat.hit          = hit_reg;
    assign stat.full         = fill_count_reg == CNT_W'(ENTRIES);
    assign stat.vic_found    = vic_found_reg;
    assign stat.vic_dirty    = vic_dirty_reg;
    assign stat.rd_dirty     = rd_data_reg.dirty;
    assign stat.dirty_zero   = dirty_count_reg == '0;
    assign stat.emitted_zero = emitted_reg == '0;
    assign stat.cap          = emitted_reg == RES_W'(MAX_RESULTS);

endmodule

// ===== rtl/core/block_cache_directory_lru_pinned_core.sv =====
// Top level of the fully associative block cache directory with LRU and pin counts.
//
//   Channel   Handshake              Payload
//   request   req_valid/req_ready    kind, block_number, slot_index
//   response  rsp_valid/rsp_ready    result_kind, slot, block_id, last
//
// One request is handled at a time, and n is the number of filled slots.
// Each walk visits the n filled slots, reading and then evaluating each
// through the single entry memory port. A hit searches the tags and then
// updates the ranks before its beat leaves. An eviction walks the same way,
// and a dirty victim's writeback beat must be taken before the rank update.
// A miss into a free slot walks once, and a get of the empty marker is
// answered from decode. Release and mark dirty read the slot and then
// answer, or answer from decode for an empty slot. Sync reads each filled
// slot and waits for each writeback beat to be taken. No clearing pass
// after reset; slots fill in order behind a fill count. A new request is
// taken once the last beat has left.
module block_cache_directory_lru_pinned_core
    import bcdir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] block_number,
    input  logic [5:0]  slot_index,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  result_kind,
    output logic [5:0]  slot,
    output logic [63:0] block_id,
    output logic        last
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer.
    bcdir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Entry store and result register.
    bcdir_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .block_number (block_number),
        .slot_index   (slot_index),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .result_kind  (result_kind),
        .slot         (slot),
        .block_id     (block_id),
        .last         (last),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== verif/bcdir_checker.sv =====
// Checker for the block cache directory: predicts each response beat and compares it.
module bcdir_checker
    import bcdir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] block_number,
    input  logic [5:0]  slot_index,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [2:0]  result_kind,
    input  logic [5:0]  slot,
    input  logic [63:0] block_id,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        result_t         rkind;
        logic [5:0]      rslot;
        logic [63:0]     rblk;
        logic            rlast;
    } beat_t;

    beat_t             due_beats[$];
    logic [63:0]       tag_m  [ENTRIES];
    logic [15:0]       pin_m  [ENTRIES];
    logic              dirty_m[ENTRIES];
    int unsigned       rank_m [ENTRIES];

    assign pending = due_beats.size();

    function automatic beat_t mk(result_t k, int s, logic [63:0] b, logic l);
        beat_t r;
        r.rkind = k;
        r.rslot = s[5:0];
        r.rblk  = b;
        r.rlast = l;
        return r;
    endfunction

    function automatic int count_filled();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tag_m[i] != BLOCK_MASK) n++;
        return n;
    endfunction

    // Move slot e to the most recently used rank.
    function automatic void make_newest(int e);
        int n;
        int unsigned r;
        n = count_filled();
        r = rank_m[e];
        for (int i = 0; i < ENTRIES; i++)
            if (i != e && tag_m[i] != BLOCK_MASK && rank_m[i] > r) rank_m[i]--;
        rank_m[e] = n - 1;
    endfunction

    // Apply one request to the directory copy and queue its beats.
    function automatic void predict_request(kind_t k, logic [63:0] blk, int s);
        int victim;
        int cnt;
        victim = ENTRIES;
        cnt = 0;
        if (k == KIND_GET) begin
            if (blk == BLOCK_MASK) begin
                due_beats.push_back(mk(RES_NOFREE, 0, blk, 1'b1));
                return;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (tag_m[i] == blk) begin
                    if (pin_m[i] != PIN_MAX) pin_m[i]++;
                    make_newest(i);
                    due_beats.push_back(mk(RES_HIT, i, blk, 1'b1));
                    return;
                end
            for (int i = 0; i < ENTRIES; i++)
                if (tag_m[i] == BLOCK_MASK) begin
                    victim = i;
                    break;
                end
            if (victim == ENTRIES)
                for (int i = 0; i < ENTRIES; i++)
                    if (pin_m[i] == 0 && (victim == ENTRIES || rank_m[i] < rank_m[victim]))
                        victim = i;
            if (victim == ENTRIES) begin
                due_beats.push_back(mk(RES_NOFREE, 0, blk, 1'b1));
                return;
            end
            if (tag_m[victim] != BLOCK_MASK) begin
                if (dirty_m[victim])
                    due_beats.push_back(mk(RES_WRITEBACK, victim, tag_m[victim], 1'b0));
                tag_m[victim] = blk;
                make_newest(victim);
            end else begin
                rank_m[victim] = count_filled();
                tag_m[victim] = blk;
            end
            dirty_m[victim] = 1'b0;
            pin_m[victim] = 16'd1;
            due_beats.push_back(mk(RES_FILL, victim, blk, 1'b1));
        end else if (k == KIND_RELEASE || k == KIND_DIRTY) begin
            if (s >= ENTRIES || tag_m[s] == BLOCK_MASK) begin
                if (k == KIND_RELEASE && s < ENTRIES) begin
                    if (pin_m[s] == 0) begin
                        due_beats.push_back(mk(RES_UNDERFLOW, s, 64'd0, 1'b1));
                        return;
                    end
                    pin_m[s]--;
                end
                due_beats.push_back(mk(RES_ACK, s, 64'd0, 1'b1));
                return;
            end
            if (k == KIND_RELEASE) begin
                if (pin_m[s] == 0) begin
                    due_beats.push_back(mk(RES_UNDERFLOW, s, tag_m[s], 1'b1));
                    return;
                end
                pin_m[s]--;
            end else begin
                dirty_m[s] = 1'b1;
            end
            due_beats.push_back(mk(RES_ACK, s, tag_m[s], 1'b1));
        end else begin
            for (int i = 0; i < ENTRIES && cnt < MAX_RESULTS; i++)
                if (tag_m[i] != BLOCK_MASK && dirty_m[i]) begin
                    due_beats.push_back(mk(RES_WRITEBACK, i, tag_m[i], 1'b0));
                    dirty_m[i] = 1'b0;
                    cnt++;
                end
            if (cnt == 0) due_beats.push_back(mk(RES_ACK, 0, 64'd0, 1'b1));
            else due_beats[$].rlast = 1'b1;
        end
    endfunction

    // Watch both channels at each rising edge.
    always @(posedge clk or negedge rst_n) begin
        beat_t want;
        if (!rst_n) begin
            fail_count <= 0;
            due_beats.delete();
            for (int i = 0; i < ENTRIES; i++) begin
                tag_m[i] = BLOCK_MASK;
                pin_m[i] = '0;
                dirty_m[i] = 1'b0;
                rank_m[i] = 0;
            end
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (due_beats.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected beat: kind %0d slot %0d blk %h last %0d",
                                 result_kind, slot, block_id, last);
                    fail_count <= fail_count + 1;
                end else begin
                    want = due_beats.pop_front();
                    if (want.rkind !== result_kind || want.rslot !== slot ||
                        want.rblk !== block_id || want.rlast !== last) begin
                        if (fail_count < 10)
                            $display("mismatch: want %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                                     want.rkind, want.rslot, want.rblk, want.rlast,
                                     result_kind, slot, block_id, last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                predict_request(kind_t'(kind), block_number, slot_index);
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the block cache directory: stimulus, idling and verdict.
module tb;
    import bcdir_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  kind;
    logic [63:0] block_number;
    logic [5:0]  slot_index;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [2:0]  result_kind;
    logic [5:0]  slot;
    logic [63:0] block_id;
    logic        last;
    int          fail_count;
    int          pending;
    int          cycles;
    logic        long_hold;
    logic [63:0] pool[8];

    block_cache_directory_lru_pinned_core dut (.*);

    bcdir_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stall pattern, overridden by a long hold-off.
    always @(posedge clk)
    begin
        if (long_hold) rsp_ready <= 1'b0;
        else if (($urandom & 15) < 3) rsp_ready <= ($urandom & 3) == 0;
        else rsp_ready <= cycles[6] || (($urandom & 1) != 0);
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one request beat and wait until it is taken; valid stays up for
    // the caller to reuse or drop.
    task automatic send_req(kind_t k, logic [63:0] b, logic [5:0] s);
        req_valid    <= 1'b1;
        kind         <= k;
        block_number <= b;
        slot_index   <= s;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic random_gap();
        if (($urandom & 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic random_req();
        int r;
        logic [63:0] b;
        r = $urandom_range(0, 99);
        b = ($urandom & 1) ? pool[$urandom_range(0, 7)] + $urandom_range(0, 90)
                           : {$urandom, $urandom};
        if (r < 45) send_req(KIND_GET, (b == BLOCK_MASK) ? 64'd5 : b, 6'd0);
        else if (r < 70) send_req(KIND_RELEASE, {$urandom, $urandom}, 6'($urandom));
        else if (r < 88) send_req(KIND_DIRTY, {$urandom, $urandom}, 6'($urandom));
        else if (r < 97) send_req(KIND_SYNC, {$urandom, $urandom}, 6'($urandom));
        else send_req(KIND_GET, BLOCK_MASK, 6'($urandom));
    endtask

    // Stop sending and wait until every expected beat has come.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        kind = KIND_GET;
        block_number = '0;
        slot_index = '0;
        rsp_ready = 1'b0;
        cycles = 0;
        long_hold = 1'b0;
        for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes and each special case.
        send_req(KIND_SYNC, 64'd0, 6'd0);
        send_req(KIND_GET, BLOCK_MASK, 6'd0);
        send_req(KIND_GET, 64'd0, 6'h3f);
        send_req(KIND_GET, 64'hFFFF_FFFF_FFFF_FFFE, 6'd0);
        send_req(KIND_GET, 64'd0, 6'd0);
        send_req(KIND_RELEASE, 64'd0, 6'd0);
        send_req(KIND_RELEASE, 64'd0, 6'd0);
        send_req(KIND_RELEASE, 64'd0, 6'd0);
        send_req(KIND_RELEASE, BLOCK_MASK, 6'd63);
        send_req(KIND_DIRTY, 64'd0, 6'd63);
        send_req(KIND_DIRTY, 64'd0, 6'd1);
        send_req(KIND_DIRTY, 64'd0, 6'd0);
        send_req(KIND_SYNC, 64'd0, 6'd0);
        send_req(KIND_DIRTY, 64'd0, 6'd1);
        send_req(KIND_SYNC, BLOCK_MASK, 6'h3f);
        drain();

        // Fill every slot and pin them all, then a miss finds no free entry.
        for (int i = 0; i < 64; i++) send_req(KIND_GET, 64'd100 + i, 6'd0);
        send_req(KIND_GET, 64'd9999, 6'd0);
        // Unpin a few, dirty them, and force dirty evictions.
        for (int i = 0; i < 64; i += 9)
        begin
            send_req(KIND_RELEASE, 64'd0, 6'(i));
            send_req(KIND_DIRTY, 64'd0, 6'(i));
        end
        for (int i = 0; i < 10; i++) send_req(KIND_GET, 64'd5000 + i, 6'd0);
        for (int i = 0; i < 64; i += 8) send_req(KIND_DIRTY, 64'd0, 6'(i));
        drain();

        // Long receiver hold while requests keep coming.
        fork
        begin
            long_hold <= 1'b1;
            repeat (600) @(posedge clk);
            long_hold <= 1'b0;
        end
        begin
            send_req(KIND_SYNC, 64'd0, 6'd0);
            for (int i = 0; i < 6; i++) send_req(KIND_DIRTY, 64'd0, 6'(i));
            req_valid <= 1'b0;
        end
        join
        drain();

        // Random part in bursts.
        for (int n = 0; n < 40; n++)
        begin
            random_req();
            random_gap();
            if (n % 20 == 19) drain();
        end
        drain();

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
